// ===== src/hvt_pkg.sv =====
`default_nettype none
package hvt_pkg;

	localparam int FIELD_W   = 32;
	localparam int COEF_W    = 32;
	localparam int NUM_PAIRS = 8;
	localparam int PAIR_W    = 2 * COEF_W;
	localparam int IDX_W     = $clog2(NUM_PAIRS);

	typedef logic [PAIR_W-1:0] coef_pair_t;

	// Reset contents give the identity matrix.
	localparam coef_pair_t PAIR_RESET [NUM_PAIRS] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000,
		64'h0,                   64'h0001_0000_0000_0000
	};

endpackage
`default_nettype wire

// ===== src/hvt_if.sv =====
`default_nettype none
interface hvt_point_if import hvt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] point_x;
	logic signed [FIELD_W-1:0] point_y;
	logic signed [FIELD_W-1:0] point_z;
	logic                      perspective;

	modport source (output valid, point_x, point_y, point_z, perspective, input ready);
	modport sink (input valid, point_x, point_y, point_z, perspective, output ready);
endinterface

interface hvt_result_if import hvt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] out_x;
	logic signed [FIELD_W-1:0] out_y;
	logic signed [FIELD_W-1:0] out_z;
	logic                      w_zero;
	logic                      saturated;

	modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/hvt_row.sv =====
`default_nettype none
module hvt_row import hvt_pkg::*; #(
	parameter int CW = 32,
	parameter int F  = 16,
	parameter int SW = 50
) (
	input  wire logic                     clk,
	input  wire logic                     en_s1,
	input  wire logic                     en_s2,
	input  wire logic signed [CW-1:0]     px,
	input  wire logic signed [CW-1:0]     py,
	input  wire logic signed [CW-1:0]     pz,
	input  wire logic signed [COEF_W-1:0] cx,
	input  wire logic signed [COEF_W-1:0] cy,
	input  wire logic signed [COEF_W-1:0] cz,
	input  wire logic signed [COEF_W-1:0] ct,
	output logic signed [SW-1:0]          sum_s2
);
	localparam int PRW = CW + COEF_W;

	logic signed [PRW-1:0] prx_s1, pry_s1, prz_s1;
	logic signed [PRW-F-1:0] shx, shy, shz;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prx_s1 <= px * cx;
			pry_s1 <= py * cy;
			prz_s1 <= pz * cz;
		end
	end

	// An arithmetic shift is the floor of the division by the fraction scale.
	assign shx = prx_s1[PRW-1:F];
	assign shy = pry_s1[PRW-1:F];
	assign shz = prz_s1[PRW-1:F];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2 <= SW'(ct) + SW'(shx) + SW'(shy) + SW'(shz);
		end
	end
endmodule
`default_nettype wire

// ===== src/hvt_div_cell.sv =====
`default_nettype none
module hvt_div_cell #(
	parameter int SW = 50,
	parameter int QB = 33
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [SW-1:0] rem_in,
	input  wire logic [QB-1:0] dq_in,
	input  wire logic [SW-1:0] den_in,
	output logic [SW-1:0]      rem_q,
	output logic [QB-1:0]      dq_q,
	output logic [SW-1:0]      den_q
);
	logic [SW:0] trial;
	logic [SW:0] diff;
	logic        take;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_in, dq_in[QB-1]};
		diff  = trial - {1'b0, den_in};
		take  = trial >= {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? diff[SW-1:0] : trial[SW-1:0];
			dq_q  <= {dq_in[QB-2:0], take};
			den_q <= den_in;
		end
	end
endmodule
`default_nettype wire

// ===== src/homogeneous_vertex_transform.sv =====
// Throughput: one point per cycle unless the output stalls; the divider is a chain of one cell per quotient bit.
// Every stage stalls on its own, so bubbles close up while the output waits.
// Reset clears the valid bits and loads the identity matrix.
`default_nettype none
module homogeneous_vertex_transform import hvt_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	hvt_point_if.sink               point,
	hvt_result_if.source            result,
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [PAIR_W-1:0]  cfg_data
);
	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	// Width of a shifted product, and of a row sum with the translation term.
	localparam int PW  = CW + COEF_W - F;
	localparam int SW  = ((PW > COEF_W) ? PW : COEF_W) + 2;
	// Quotient bits: enough to tell any magnitude inside the range from one outside it.
	localparam int QB  = CW + 1;
	localparam int XW  = SW + ((F > QB) ? F : QB);
	// Stages: products, sums, divider setup, QB divider cells, output.
	localparam int NS  = QB + 4;
	localparam int CS  = 3;

	localparam logic signed [SW-1:0] AHI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] ALO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
	localparam logic [QB-1:0] QHI = {2'b00, {(CW-1){1'b1}}};
	localparam logic [QB-1:0] QLO = {2'b01, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] CHI = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CLO = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic                       persp;
		logic                       wz;
		logic [2:0]                 neg;
		logic [2:0]                 ovf;
		logic [2:0]                 asat;
		logic [2:0][CW-1:0]         aff;
	} side_t;

	// Configuration registers.
	coef_pair_t cfg_q [NUM_PAIRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= PAIR_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Matrix element e sits in pair e/2, low half for even e.
	logic signed [COEF_W-1:0] elem [16];
	always_comb begin
		for (int e = 0; e < 16; e++) begin
			elem[e] = cfg_q[e/2][(e%2)*COEF_W +: COEF_W];
		end
	end

	// Per-stage valid bits and stall chain: a stage moves when it is empty
	// or the stage after it moves.
	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = result.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? point.valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign point.ready = en[0];

	// Coordinates use the low COORD_WIDTH bits of their field.
	logic signed [CW-1:0] px, py, pz;
	assign px = point.point_x[CW-1:0];
	assign py = point.point_y[CW-1:0];
	assign pz = point.point_z[CW-1:0];

	logic persp_s1, persp_s2;
	always_ff @(posedge clk) begin
		if (en[0]) persp_s1 <= point.perspective;
		if (en[1]) persp_s2 <= persp_s1;
	end

	// Four row units: x, y, z and w.
	logic signed [SW-1:0] sum_s2 [4];
	for (genvar r = 0; r < 4; r++) begin : g_row
		hvt_row #(.CW(CW), .F(F), .SW(SW)) u_row (
			.clk    (clk),
			.en_s1  (en[0]),
			.en_s2  (en[1]),
			.px     (px),
			.py     (py),
			.pz     (pz),
			.cx     (elem[r]),
			.cy     (elem[4 + r]),
			.cz     (elem[8 + r]),
			.ct     (elem[12 + r]),
			.sum_s2 (sum_s2[r])
		);
	end

	// Divider setup: magnitudes, zero and overflow checks, affine results.
	logic [SW-1:0] den_abs;
	logic [SW-1:0] num_abs [3];
	logic [XW-1:0] num_x [3];
	logic [XW-1:0] den_x;
	side_t         side_d;

	always_comb begin
		den_abs      = sum_s2[3][SW-1] ? SW'(-sum_s2[3]) : sum_s2[3];
		den_x        = XW'(den_abs) << QB;
		side_d       = '0;
		side_d.persp = persp_s2;
		side_d.wz    = sum_s2[3] == '0;
		for (int l = 0; l < 3; l++) begin
			num_abs[l]     = sum_s2[l][SW-1] ? SW'(-sum_s2[l]) : sum_s2[l];
			num_x[l]       = XW'(num_abs[l]) << F;
			side_d.neg[l]  = sum_s2[l][SW-1] ^ sum_s2[3][SW-1];
			side_d.ovf[l]  = num_x[l] >= den_x;
			if (sum_s2[l] > AHI) begin
				side_d.aff[l]  = CHI;
				side_d.asat[l] = 1'b1;
			end else if (sum_s2[l] < ALO) begin
				side_d.aff[l]  = CLO;
				side_d.asat[l] = 1'b1;
			end else begin
				side_d.aff[l]  = sum_s2[l][CW-1:0];
			end
		end
	end

	// Side information travels alongside the divider cells, one register per
	// stage from the setup stage to the last cell.
	side_t side_q [CS-1:NS-2];
	always_ff @(posedge clk) begin
		if (en[CS-1]) side_q[CS-1] <= side_d;
		for (int k = CS; k <= NS - 2; k++) begin
			if (en[k]) side_q[k] <= side_q[k-1];
		end
	end

	// Divider chains, one per coordinate lane. Entry 0 is the setup register.
	logic [SW-1:0] rem_c [3][QB+1];
	logic [QB-1:0] dq_c  [3][QB+1];
	logic [SW-1:0] den_c [3][QB+1];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en[2]) begin
				rem_c[l][0] <= num_x[l][QB+SW-1:QB];
				dq_c[l][0]  <= num_x[l][QB-1:0];
				den_c[l][0] <= den_abs;
			end
		end
		for (genvar j = 0; j < QB; j++) begin : g_cell
			hvt_div_cell #(.SW(SW), .QB(QB)) u_cell (
				.clk    (clk),
				.en     (en[CS + j]),
				.rem_in (rem_c[l][j]),
				.dq_in  (dq_c[l][j]),
				.den_in (den_c[l][j]),
				.rem_q  (rem_c[l][j+1]),
				.dq_q   (dq_c[l][j+1]),
				.den_q  (den_c[l][j+1])
			);
		end
	end

	// Output stage: affine pass-through, sign, saturation and the zero-w case.
	side_t                side_f;
	logic signed [CW-1:0] res_d [3];
	logic [2:0]           sat_d;
	logic [QB-1:0]        mag;

	always_comb begin
		side_f = side_q[NS-2];
		mag    = '0;
		for (int l = 0; l < 3; l++) begin
			mag      = dq_c[l][QB];
			sat_d[l] = 1'b0;
			res_d[l] = '0;
			if (!side_f.persp) begin
				res_d[l] = side_f.aff[l];
				sat_d[l] = side_f.asat[l];
			end else if (side_f.wz) begin
				res_d[l] = '0;
			end else if (side_f.ovf[l]) begin
				res_d[l] = side_f.neg[l] ? CLO : CHI;
				sat_d[l] = 1'b1;
			end else if (side_f.neg[l]) begin
				if (mag > QLO) begin
					res_d[l] = CLO;
					sat_d[l] = 1'b1;
				end else begin
					res_d[l] = CW'(-mag);
				end
			end else if (mag > QHI) begin
				res_d[l] = CHI;
				sat_d[l] = 1'b1;
			end else begin
				res_d[l] = mag[CW-1:0];
			end
		end
	end

	logic signed [CW-1:0] res_q [3];
	logic                 wz_q, sat_q;

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res_q <= res_d;
			wz_q  <= side_f.persp & side_f.wz;
			sat_q <= |sat_d;
		end
	end

	assign result.valid     = vld_q[NS-1];
	assign result.out_x     = FIELD_W'(res_q[0]);
	assign result.out_y     = FIELD_W'(res_q[1]);
	assign result.out_z     = FIELD_W'(res_q[2]);
	assign result.w_zero    = wz_q;
	assign result.saturated = sat_q;

	// A zero w always comes with zero coordinates and no clipping.
	a_wzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.w_zero |->
			result.out_x == 0 && result.out_y == 0 && result.out_z == 0 && !result.saturated)
		else $error("w_zero result carries nonzero data");

	// An accepted word always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> vld_q[0])
		else $error("accepted word lost at pipeline entry");

	// A waiting result is held, never replaced, while the sink stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.out_x))
		else $error("stalled result changed");

	// With an empty entry stage the input side is never stalled.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> point.ready)
		else $error("input stalled with an empty entry stage");
endmodule
`default_nettype wire

// ===== tb/tb_homogeneous_vertex_transform.sv =====
`default_nettype none
module tb_homogeneous_vertex_transform;
	import hvt_pkg::*;

	// Pipeline depth of the block at the default parameters.
	localparam int PIPE_DEPTH  = 37;
	localparam int FRAC        = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_RANDOM  = 850;

	typedef struct {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
		logic                      w_zero;
		logic                      saturated;
	} vertex_t;

	// Keeps its own copy of the matrix, predicts each accepted point and checks
	// each delivered word against the oldest prediction.
	class vertex_transform_checker;
		coef_pair_t matrix [NUM_PAIRS];
		vertex_t    expected_vertices [$];
		int         mismatches;

		function new();
			for (int i = 0; i < NUM_PAIRS; i++)
				matrix[i] = PAIR_RESET[i];
			mismatches = 0;
		endfunction

		function void load_pair(int idx, coef_pair_t value);
			matrix[idx] = value;
		endfunction

		function longint element(int idx);
			logic signed [COEF_W-1:0] half;
			half = idx[0] ? matrix[idx >> 1][63:32] : matrix[idx >> 1][31:0];
			return longint'(half);
		endfunction

		// Dot product of the point with one matrix row; each product is floored
		// to the fraction width, translation added as is.
		function longint row_sum(longint p [3], int r);
			longint acc;
			acc = element(12 + r);
			for (int c = 0; c < 3; c++)
				acc += (p[c] * element(4 * c + r)) >>> FRAC;
			return acc;
		endfunction

		// Magnitude divide, truncated toward zero; huge quotients go far out of
		// range so that they saturate.
		function longint scaled_divide(longint num, longint den);
			logic              neg;
			logic [63:0]       an;
			logic [63:0]       ad;
			logic [127:0]      wide;
			longint            mag;
			neg = (num < 0) != (den < 0);
			an = (num < 0) ? -num : num;
			ad = (den < 0) ? -den : den;
			if (an / ad >= 64'd1 << 38)
				return neg ? -(64'sd1 <<< 61) : (64'sd1 <<< 61);
			wide = {64'd0, an} << FRAC;
			wide = wide / {64'd0, ad};
			mag = longint'(wide[63:0]);
			return neg ? -mag : mag;
		endfunction

		function logic signed [FIELD_W-1:0] clip(longint v, ref logic sat);
			if (v > 64'sd2147483647) begin
				sat = 1'b1;
				return 32'sh7fff_ffff;
			end
			if (v < -64'sd2147483648) begin
				sat = 1'b1;
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		function void note_point(logic signed [FIELD_W-1:0] px, logic signed [FIELD_W-1:0] py,
				logic signed [FIELD_W-1:0] pz, logic persp);
			longint  p [3];
			longint  res [3];
			longint  w;
			logic    sat;
			vertex_t v;
			p[0] = longint'(px);
			p[1] = longint'(py);
			p[2] = longint'(pz);
			for (int r = 0; r < 3; r++)
				res[r] = row_sum(p, r);
			v.w_zero = 1'b0;
			if (persp) begin
				w = row_sum(p, 3);
				if (w == 0) begin
					v.w_zero = 1'b1;
					res = '{0, 0, 0};
				end else begin
					for (int r = 0; r < 3; r++)
						res[r] = scaled_divide(res[r], w);
				end
			end
			sat = 1'b0;
			v.x = clip(res[0], sat);
			v.y = clip(res[1], sat);
			v.z = clip(res[2], sat);
			v.saturated = sat;
			expected_vertices.push_back(v);
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t want;
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: x=%h y=%h z=%h", got.x, got.y, got.z);
				return;
			end
			want = expected_vertices.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
					got.w_zero !== want.w_zero || got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected x=%h y=%h z=%h wz=%b sat=%b, got x=%h y=%h z=%h wz=%b sat=%b",
						want.x, want.y, want.z, want.w_zero, want.saturated,
						got.x, got.y, got.z, got.w_zero, got.saturated);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	coef_pair_t       cfg_data;

	hvt_point_if  point_ch ();
	hvt_result_if result_ch ();

	homogeneous_vertex_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	vertex_transform_checker checker_h;
	int  burst_left;
	int  results_seen;
	int  idle_cycles;
	int  hold_left;
	bit  hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every input starts at a known value before reset is released.
	initial begin
		checker_h = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point_ch.valid = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		point_ch.point_z = '0;
		point_ch.perspective = 1'b0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Monitors: both channels are sampled at the rising edge, so the checker
	// sees what the block saw.
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready)
			checker_h.note_point(point_ch.point_x, point_ch.point_y, point_ch.point_z,
				point_ch.perspective);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			checker_h.check_vertex('{result_ch.out_x, result_ch.out_y, result_ch.out_z,
				result_ch.w_zero, result_ch.saturated});
			results_seen++;
		end
	end

	// Watchdog: any cycle with no word moving on either channel counts toward
	// the limit, which covers the long hold-off and the pauses between phases.
	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stalls on its own pattern. Once, after a few hundred words, it
	// holds off for a long stretch so the pipeline fills and backs up.
	initial begin
		results_seen = 0;
		idle_cycles = 0;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready = 1'b0;
			end else if ((results_seen / 64) % 3 == 0) begin
				result_ch.ready = 1'b1;
			end else begin
				result_ch.ready = ($urandom_range(0, 99) < 65);
			end
		end
	end

	// Offers one point and waits for the handshake. Between bursts the sender
	// drops valid for a random gap.
	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic persp);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			point_ch.valid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		burst_left--;
		point_ch.valid = 1'b1;
		point_ch.point_x = px;
		point_ch.point_y = py;
		point_ch.point_z = pz;
		point_ch.perspective = persp;
		do
			@(posedge clk);
		while (!point_ch.ready);
		@(negedge clk);
	endtask

	// Waits until every prediction is answered and the pipeline is empty, then
	// loads a full matrix while the block is idle.
	task automatic load_matrix(coef_pair_t pairs [NUM_PAIRS]);
		point_ch.valid = 1'b0;
		while (checker_h.expected_vertices.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 5) @(negedge clk);
		for (int i = 0; i < NUM_PAIRS; i++) begin
			cfg_we = 1'b1;
			cfg_index = i[IDX_W-1:0];
			cfg_data = pairs[i];
			checker_h.load_pair(i, pairs[i]);
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	// Coefficient flavors: small values keep most results in range, full
	// values exercise every bit, and the extremes hit saturation.
	function automatic logic [31:0] pick_coef(int flavor);
		case (flavor)
			0: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
			1: return $urandom();
			default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC));
			2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
			default: return 32'($signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
		endcase
	endfunction

	initial begin
		coef_pair_t pairs [NUM_PAIRS];
		logic [31:0] m [16];
		int flavor;
		burst_left = 0;
		@(posedge arst_n);
		@(negedge clk);

		// Identity matrix straight from reset: extreme coordinates in both modes;
		// perspective divides by a w of one.
		send_point(32'h0, 32'h0, 32'h0, 1'b0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
		send_point(32'h0, 32'h0, 32'h0, 1'b1);
		send_point(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 1'b1);

		// All-maximum matrix: sums overflow and saturate in both directions.
		for (int i = 0; i < NUM_PAIRS; i++)
			pairs[i] = 64'h7fff_ffff_7fff_ffff;
		load_matrix(pairs);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h0, 32'h0, 32'h0, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);

		// All-minimum matrix.
		for (int i = 0; i < NUM_PAIRS; i++)
			pairs[i] = 64'h8000_0000_8000_0000;
		load_matrix(pairs);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
		send_point(32'h0001_0000, 32'h0, 32'h0, 1'b1);
		send_point(32'h0, 32'h0, 32'h0, 1'b1);

		// Perspective matrix with w = -z: a zero z gives a zero w, and a tiny w
		// drives the quotient out of range.
		pairs = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
			64'h0, 64'hffff_0000_0001_0000, 64'h0, 64'h0000_0000_0000_0000};
		load_matrix(pairs);
		send_point(32'h0003_0000, 32'h0002_0000, 32'h0, 1'b1);
		send_point(32'h0003_0000, 32'h0002_0000, 32'h0, 1'b0);
		send_point(32'h0003_0000, 32'hfffe_0000, 32'hfffc_0000, 1'b1);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
		send_point(32'h0010_0000, 32'h0010_0000, 32'h0008_0000, 1'b1);

		// Random part: a fresh matrix every phase. Some phases clear the w row
		// so that perspective points take the zero-w path.
		for (int phase = 0; phase < 10; phase++) begin
			flavor = (phase == 9) ? 2 : (phase % 3 == 1) ? 1 : 0;
			for (int i = 0; i < 16; i++)
				m[i] = pick_coef(flavor);
			if (phase % 4 == 3) begin
				m[3] = 32'h0;
				m[7] = 32'h0;
				m[11] = 32'h0;
				m[15] = 32'h0;
			end
			for (int i = 0; i < NUM_PAIRS; i++)
				pairs[i] = {m[2 * i + 1], m[2 * i]};
			load_matrix(pairs);
			for (int n = 0; n < NUM_RANDOM / 10; n++)
				send_point(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
		end

		point_ch.valid = 1'b0;
		while (checker_h.expected_vertices.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 5) @(negedge clk);
		if (checker_h.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== homogeneous_vertex_transform.f =====
src/hvt_pkg.sv
src/hvt_if.sv
src/hvt_row.sv
src/hvt_div_cell.sv
src/homogeneous_vertex_transform.sv
tb/tb_homogeneous_vertex_transform.sv
